// File: design/dns_pkg.sv
package dns_pkg;

	localparam int TOK_W         = 7;
	localparam int CNT_W         = 16;
	localparam int MAX_RES       = 3;
	localparam logic [TOK_W-1:0] MAX_TOKEN_LEN = 7'd127;

	localparam logic [2:0] PH_IDLE     = 3'd0;
	localparam logic [2:0] PH_COMMENT  = 3'd1;
	localparam logic [2:0] PH_MANT     = 3'd2;
	localparam logic [2:0] PH_EXPSIGN  = 3'd3;
	localparam logic [2:0] PH_EXPDIG   = 3'd4;
	localparam logic [2:0] PH_STOP_OK  = 3'd5;
	localparam logic [2:0] PH_STOP_ERR = 3'd6;

	localparam logic IN_BYTE = 1'b0;
	localparam logic IN_END  = 1'b1;

	localparam logic [1:0] RK_CHAR = 2'd0;
	localparam logic [1:0] RK_END  = 2'd1;
	localparam logic [1:0] RK_DONE = 2'd2;

	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_LOW_E = 8'h65;
	localparam logic [7:0] CH_UP_E  = 8'h45;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       ch;
		logic [CNT_W-1:0] cnt;
		logic             st;
	} res_t;

	function automatic res_t mk_res(input logic [1:0] kind, input logic [7:0] ch,
			input logic [CNT_W-1:0] cnt, input logic st);
		res_t r;
		r.kind = kind;
		r.ch   = ch;
		r.cnt  = cnt;
		r.st   = st;
		return r;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_sign(input logic [7:0] c);
		return (c == CH_MINUS) || (c == CH_PLUS);
	endfunction

endpackage

// File: design/decimal_number_scanner.sv
// Channel  | Handshake                 | Payload
// item     | item_valid / item_ready   | kind, text_byte
// result   | result_valid / result_ready | result_kind, number_char, numbers_read,
//          |                           |   status, last_of_run
// cfg      | cfg_valid / cfg_ready     | cfg_data (number_limit)
//
// One request is taken per cycle while item_ready is high; its results (up to three)
// land in a result buffer the cycle after acceptance and leave one per cycle while result_ready is high.
// A request that yields results keeps item_ready low until the last of them
// is leaving the buffer; a request with no result leaves item_ready high.
// item_ready is high when the buffer is empty or its last entry leaves now.
// Reset clears scan state, the count and the buffer; number_limit returns to 1.
module decimal_number_scanner (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_ready,
	input  logic                      kind,
	input  logic [7:0]                text_byte,
	output logic                      result_valid,
	input  logic                      result_ready,
	output logic [1:0]                result_kind,
	output logic [7:0]                number_char,
	output logic [dns_pkg::CNT_W-1:0] numbers_read,
	output logic                      status,
	output logic                      last_of_run,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [dns_pkg::CNT_W-1:0] cfg_data
);
	import dns_pkg::*;

	logic [CNT_W-1:0] limit_q;
	logic [2:0]       phase_q, phase_d;
	logic [7:0]       held_q [0:1];
	logic [7:0]       held0_d, held1_d;
	logic [1:0]       hc_q, hc_d;
	logic             dot_q, dot_d;
	logic             dig_q, dig_d;
	logic [TOK_W-1:0] len_q, len_d;
	logic [CNT_W-1:0] cnt_q, cnt_d, cnt_inc;

	res_t             res [0:MAX_RES-1];
	logic [1:0]       n_v;
	res_t             buf_q [0:MAX_RES-1];
	logic             last_q [0:MAX_RES-1];
	logic [1:0]       rcnt_q;

	logic             idle_scan, idle_char, end_rescan, emit_one, hold_c;
	logic [2:0]       emit_next;
	logic             item_fire, result_fire;

	assign item_fire   = item_valid && item_ready;
	assign result_fire = result_valid && result_ready;
	assign item_ready  = (rcnt_q == 2'd0) || ((rcnt_q == 2'd1) && result_ready);
	assign cfg_ready   = 1'b1;
	assign cnt_inc     = cnt_q + 16'd1;

	always_comb begin
		phase_d    = phase_q;
		held0_d    = held_q[0];
		held1_d    = held_q[1];
		hc_d       = hc_q;
		dot_d      = dot_q;
		dig_d      = dig_q;
		len_d      = len_q;
		cnt_d      = cnt_q;
		res[0]     = '0;
		res[1]     = '0;
		res[2]     = '0;
		n_v        = 2'd0;
		idle_scan  = 1'b0;
		idle_char  = 1'b0;
		end_rescan = 1'b0;
		emit_one   = 1'b0;
		hold_c     = 1'b0;
		emit_next  = phase_q;

		if (kind == IN_BYTE) begin
			unique case (phase_q)
				PH_IDLE: begin
					idle_scan = 1'b1;
				end
				PH_COMMENT: begin
					if (text_byte == CH_NL)
						phase_d = PH_IDLE;
				end
				PH_MANT: begin
					priority if (is_digit(text_byte)) begin
						if (!dig_q) begin
							dig_d = 1'b1;
							if (hc_q != 2'd0) begin
								res[n_v] = mk_res(RK_CHAR, held_q[0], '0, 1'b0);
								n_v = n_v + 2'd1;
							end
							if (hc_q == 2'd2) begin
								res[n_v] = mk_res(RK_CHAR, held_q[1], '0, 1'b0);
								n_v = n_v + 2'd1;
							end
							res[n_v] = mk_res(RK_CHAR, text_byte, '0, 1'b0);
							n_v = n_v + 2'd1;
							len_d = TOK_W'(hc_q) + 7'd1;
							hc_d  = 2'd0;
						end else begin
							emit_one = 1'b1;
						end
					end else if ((text_byte == CH_DOT) && !dot_q) begin
						dot_d = 1'b1;
						if (dig_q)
							emit_one = 1'b1;
						else
							hold_c = 1'b1;
					end else if (!dig_q) begin
						idle_scan = 1'b1;
					end else if ((text_byte == CH_LOW_E) || (text_byte == CH_UP_E)) begin
						emit_one  = 1'b1;
						emit_next = PH_EXPSIGN;
					end else begin
						end_rescan = 1'b1;
					end
				end
				PH_EXPSIGN: begin
					if (is_sign(text_byte) || is_digit(text_byte)) begin
						emit_one  = 1'b1;
						emit_next = PH_EXPDIG;
					end else begin
						end_rescan = 1'b1;
					end
				end
				PH_EXPDIG: begin
					if (is_digit(text_byte))
						emit_one = 1'b1;
					else
						end_rescan = 1'b1;
				end
				default: begin
				end
			endcase

			if (emit_one) begin
				if (len_q >= MAX_TOKEN_LEN) begin
					res[n_v] = mk_res(RK_END, '0, cnt_q, 1'b1);
					n_v = n_v + 2'd1;
					res[n_v] = mk_res(RK_DONE, '0, cnt_q, 1'b1);
					n_v = n_v + 2'd1;
					hc_d    = 2'd0;
					dot_d   = 1'b0;
					dig_d   = 1'b0;
					len_d   = '0;
					phase_d = PH_STOP_ERR;
				end else begin
					res[n_v] = mk_res(RK_CHAR, text_byte, '0, 1'b0);
					n_v = n_v + 2'd1;
					len_d   = len_q + 7'd1;
					phase_d = emit_next;
				end
			end

			if (hold_c && (hc_q < 2'd2)) begin
				if (hc_q[0])
					held1_d = text_byte;
				else
					held0_d = text_byte;
				hc_d = hc_q + 2'd1;
			end

			if (end_rescan) begin
				cnt_d = cnt_inc;
				res[n_v] = mk_res(RK_END, '0, cnt_inc, 1'b0);
				n_v = n_v + 2'd1;
				hc_d  = 2'd0;
				dot_d = 1'b0;
				dig_d = 1'b0;
				len_d = '0;
				if (cnt_inc >= limit_q) begin
					res[n_v] = mk_res(RK_DONE, '0, cnt_inc, 1'b0);
					n_v = n_v + 2'd1;
					phase_d = PH_STOP_OK;
				end else begin
					idle_char = 1'b1;
				end
			end

			if (idle_scan) begin
				hc_d  = 2'd0;
				dot_d = 1'b0;
				dig_d = 1'b0;
				len_d = '0;
				if (cnt_q >= limit_q) begin
					res[n_v] = mk_res(RK_DONE, '0, cnt_q, 1'b0);
					n_v = n_v + 2'd1;
					phase_d = PH_STOP_OK;
				end else begin
					idle_char = 1'b1;
				end
			end

			if (idle_char) begin
				phase_d = PH_IDLE;
				priority if (text_byte == CH_HASH) begin
					phase_d = PH_COMMENT;
				end else if (text_byte == CH_DOT) begin
					held0_d = text_byte;
					hc_d    = 2'd1;
					dot_d   = 1'b1;
					phase_d = PH_MANT;
				end else if (is_sign(text_byte)) begin
					held0_d = text_byte;
					hc_d    = 2'd1;
					phase_d = PH_MANT;
				end else if (is_digit(text_byte)) begin
					dig_d   = 1'b1;
					phase_d = PH_MANT;
					res[n_v] = mk_res(RK_CHAR, text_byte, '0, 1'b0);
					n_v = n_v + 2'd1;
					len_d = 7'd1;
				end else begin
				end
			end
		end else begin
			if ((phase_q == PH_STOP_OK) || (phase_q == PH_STOP_ERR)) begin
				res[n_v] = mk_res(RK_DONE, '0, cnt_q, phase_q == PH_STOP_ERR);
				n_v = n_v + 2'd1;
			end else if (((phase_q == PH_MANT) || (phase_q == PH_EXPSIGN) ||
					(phase_q == PH_EXPDIG)) && dig_q) begin
				res[n_v] = mk_res(RK_END, '0, cnt_inc, 1'b0);
				n_v = n_v + 2'd1;
				res[n_v] = mk_res(RK_DONE, '0, cnt_inc, 1'b0);
				n_v = n_v + 2'd1;
			end else begin
				res[n_v] = mk_res(RK_DONE, '0, cnt_q, 1'b0);
				n_v = n_v + 2'd1;
			end
			hc_d    = 2'd0;
			dot_d   = 1'b0;
			dig_d   = 1'b0;
			len_d   = '0;
			cnt_d   = '0;
			phase_d = PH_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= 16'd1;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			hc_q    <= 2'd0;
			dot_q   <= 1'b0;
			dig_q   <= 1'b0;
			len_q   <= '0;
			cnt_q   <= '0;
		end else if (item_fire) begin
			phase_q <= phase_d;
			hc_q    <= hc_d;
			dot_q   <= dot_d;
			dig_q   <= dig_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (item_fire) begin
			held_q[0] <= held0_d;
			held_q[1] <= held1_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcnt_q <= 2'd0;
		end else if (item_fire) begin
			rcnt_q <= n_v;
		end else if (result_fire) begin
			rcnt_q <= rcnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (item_fire) begin
			buf_q[0]  <= res[0];
			buf_q[1]  <= res[1];
			buf_q[2]  <= res[2];
			last_q[0] <= (n_v == 2'd1);
			last_q[1] <= (n_v == 2'd2);
			last_q[2] <= (n_v == 2'd3);
		end else if (result_fire) begin
			buf_q[0]  <= buf_q[1];
			buf_q[1]  <= buf_q[2];
			last_q[0] <= last_q[1];
			last_q[1] <= last_q[2];
		end
	end

	assign result_valid = (rcnt_q != 2'd0);
	assign result_kind  = buf_q[0].kind;
	assign number_char  = buf_q[0].ch;
	assign numbers_read = buf_q[0].cnt;
	assign status       = buf_q[0].st;
	assign last_of_run  = last_q[0];

	a_last_entry: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (rcnt_q == 2'd1) |-> last_of_run)
		else $error("final buffered result lacks last_of_run");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result_kind != 2'd3))
		else $error("illegal result kind");

	a_stop_silent: assert property (@(posedge clk) disable iff (!arst_n)
		item_fire && (kind == IN_BYTE) &&
		((phase_q == PH_STOP_OK) || (phase_q == PH_STOP_ERR)) |=> (rcnt_q == 2'd0))
		else $error("stopped scan produced results");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		item_fire && (kind == IN_END) |=> (phase_q == PH_IDLE) && (cnt_q == '0))
		else $error("end of input did not restart the scan");

endmodule

// File: verif/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import dns_pkg::*;

	localparam int RANDOM_REQUESTS = 60;
	localparam int IDLE_LIMIT      = 3000;
	localparam int LONG_HOLD       = 300;
	localparam int SETTLE_CYCLES   = 6;
	localparam int MAX_PRINTS      = 40;

	typedef struct {
		logic [1:0]       kind;
		logic [7:0]       ch;
		logic [CNT_W-1:0] cnt;
		logic             st;
		logic             last;
	} scan_result_t;

	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             item_valid   = 1'b0;
	logic             item_ready;
	logic             kind         = IN_BYTE;
	logic [7:0]       text_byte    = 8'h00;
	logic             result_valid;
	logic             result_ready = 1'b0;
	logic [1:0]       result_kind;
	logic [7:0]       number_char;
	logic [CNT_W-1:0] numbers_read;
	logic             status;
	logic             last_of_run;
	logic             cfg_valid    = 1'b0;
	logic             cfg_ready;
	logic [CNT_W-1:0] cfg_data     = '0;

	logic [2:0]       scan_state  = PH_IDLE;
	logic [7:0]       prefix_buf [2];
	logic [1:0]       prefix_cnt  = '0;
	logic             dot_seen    = 1'b0;
	logic             digit_seen  = 1'b0;
	logic [TOK_W-1:0] token_len   = '0;
	logic [CNT_W-1:0] count_model = '0;
	logic [CNT_W-1:0] limit_model = 16'd1;

	scan_result_t burst[$];
	scan_result_t pending_results[$];

	int  error_count   = 0;
	int  requests_sent = 0;
	int  tx_idle_pct   = 0;
	int  rx_idle_pct   = 0;
	bit  long_hold_req = 1'b0;

	decimal_number_scanner uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.kind         (kind),
		.text_byte    (text_byte),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_kind  (result_kind),
		.number_char  (number_char),
		.numbers_read (numbers_read),
		.status       (status),
		.last_of_run  (last_of_run),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic bit numeral(logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic void add_result(logic [1:0] k, logic [7:0] c, logic [CNT_W-1:0] n,
			logic s);
		scan_result_t r;
		if (burst.size() >= MAX_RES)
			return;
		r.kind = k;
		r.ch   = c;
		r.cnt  = n;
		r.st   = s;
		r.last = 1'b0;
		burst.push_back(r);
	endfunction

	function automatic void reset_token();
		prefix_cnt = '0;
		dot_seen   = 1'b0;
		digit_seen = 1'b0;
		token_len  = '0;
	endfunction

	function automatic bit accept_char(logic [7:0] c);
		if (token_len >= MAX_TOKEN_LEN) begin
			add_result(RK_END, '0, count_model, 1'b1);
			add_result(RK_DONE, '0, count_model, 1'b1);
			reset_token();
			scan_state = PH_STOP_ERR;
			return 1'b0;
		end
		add_result(RK_CHAR, c, '0, 1'b0);
		token_len++;
		return 1'b1;
	endfunction

	function automatic void hold_prefix(logic [7:0] c);
		if (prefix_cnt < 2) begin
			prefix_buf[prefix_cnt[0]] = c;
			prefix_cnt++;
		end
	endfunction

	function automatic void finish_number();
		count_model++;
		add_result(RK_END, '0, count_model, 1'b0);
		reset_token();
		if (count_model >= limit_model) begin
			add_result(RK_DONE, '0, count_model, 1'b0);
			scan_state = PH_STOP_OK;
		end else begin
			scan_state = PH_IDLE;
		end
	endfunction

	function automatic void start_scan(logic [7:0] c);
		if (count_model >= limit_model) begin
			add_result(RK_DONE, '0, count_model, 1'b0);
			scan_state = PH_STOP_OK;
			return;
		end
		reset_token();
		if (c == CH_HASH) begin
			scan_state = PH_COMMENT;
		end else if (c == CH_DOT) begin
			hold_prefix(c);
			dot_seen   = 1'b1;
			scan_state = PH_MANT;
		end else if (c == CH_MINUS || c == CH_PLUS) begin
			hold_prefix(c);
			scan_state = PH_MANT;
		end else if (numeral(c)) begin
			digit_seen = 1'b1;
			scan_state = PH_MANT;
			void'(accept_char(c));
		end
	endfunction

	function automatic void end_and_rescan(logic [7:0] c);
		finish_number();
		if (scan_state == PH_IDLE)
			start_scan(c);
	endfunction

	function automatic void scan_text(logic [7:0] c);
		unique case (scan_state)
			PH_IDLE: start_scan(c);
			PH_COMMENT: begin
				if (c == CH_NL)
					scan_state = PH_IDLE;
			end
			PH_MANT: begin
				if (numeral(c)) begin
					if (!digit_seen) begin
						digit_seen = 1'b1;
						for (int i = 0; i < prefix_cnt; i++)
							if (!accept_char(prefix_buf[i]))
								return;
						prefix_cnt = '0;
					end
					void'(accept_char(c));
				end else if (c == CH_DOT && !dot_seen) begin
					dot_seen = 1'b1;
					if (digit_seen)
						void'(accept_char(c));
					else
						hold_prefix(c);
				end else if (!digit_seen) begin
					reset_token();
					scan_state = PH_IDLE;
					start_scan(c);
				end else if (c == CH_LOW_E || c == CH_UP_E) begin
					if (accept_char(c))
						scan_state = PH_EXPSIGN;
				end else begin
					end_and_rescan(c);
				end
			end
			PH_EXPSIGN: begin
				if (c == CH_MINUS || c == CH_PLUS || numeral(c)) begin
					if (accept_char(c))
						scan_state = PH_EXPDIG;
				end else begin
					end_and_rescan(c);
				end
			end
			PH_EXPDIG: begin
				if (numeral(c))
					void'(accept_char(c));
				else
					end_and_rescan(c);
			end
			default: ;
		endcase
	endfunction

	function automatic void flush_stream();
		if (scan_state == PH_STOP_OK || scan_state == PH_STOP_ERR) begin
			add_result(RK_DONE, '0, count_model, scan_state == PH_STOP_ERR);
		end else begin
			if ((scan_state == PH_MANT || scan_state == PH_EXPSIGN ||
					scan_state == PH_EXPDIG) && digit_seen) begin
				count_model++;
				add_result(RK_END, '0, count_model, 1'b0);
			end
			add_result(RK_DONE, '0, count_model, 1'b0);
		end
		reset_token();
		count_model = '0;
		scan_state  = PH_IDLE;
	endfunction

	function automatic void predict_request(logic k, logic [7:0] c);
		burst.delete();
		if (k == IN_BYTE)
			scan_text(c);
		else
			flush_stream();
		if (burst.size() > 0)
			burst[burst.size() - 1].last = 1'b1;
		foreach (burst[i])
			pending_results.push_back(burst[i]);
	endfunction

	function automatic int idle_gap();
		int r;
		r = $urandom_range(99);
		if (r < 75)
			return $urandom_range(2, 1);
		if (r < 95)
			return $urandom_range(8, 3);
		return $urandom_range(40, 15);
	endfunction

	task automatic report_mismatch(string what);
		error_count++;
		if (error_count <= MAX_PRINTS)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	always @(posedge clk) begin
		scan_result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind %0d", result_kind));
			end else begin
				want = pending_results.pop_front();
				check_field("result_kind", 32'(result_kind), 32'(want.kind));
				check_field("number_char", 32'(number_char), 32'(want.ch));
				check_field("numbers_read", 32'(numbers_read), 32'(want.cnt));
				check_field("status", 32'(status), 32'(want.st));
				check_field("last_of_run", 32'(last_of_run), 32'(want.last));
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				result_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if ($urandom_range(99) < rx_idle_pct) begin
				result_ready <= 1'b0;
				repeat (idle_gap()) @(posedge clk);
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((item_valid && item_ready) || (result_valid && result_ready) ||
					(cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic send_request(logic k, logic [7:0] c);
		int gap;
		gap = ($urandom_range(99) < tx_idle_pct) ? idle_gap() : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		kind       <= k;
		text_byte  <= c;
		do
			@(posedge clk);
		while (!(item_valid && item_ready));
		predict_request(k, c);
		requests_sent++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_request(IN_BYTE, s[i]);
	endtask

	task automatic send_end();
		send_request(IN_END, 8'($urandom_range(255)));
	endtask

	task automatic send_digit();
		send_request(IN_BYTE, 8'(CH_ZERO + $urandom_range(9)));
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(logic [CNT_W-1:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		limit_model = value;
		cfg_valid <= 1'b0;
	endtask

	task automatic send_token();
		if ($urandom_range(99) < 35)
			send_request(IN_BYTE, $urandom_range(1) ? CH_MINUS : CH_PLUS);
		repeat ($urandom_range(4)) send_digit();
		if ($urandom_range(99) < 40) begin
			send_request(IN_BYTE, CH_DOT);
			repeat ($urandom_range(3)) send_digit();
		end
		if ($urandom_range(99) < 30) begin
			send_request(IN_BYTE, $urandom_range(1) ? CH_LOW_E : CH_UP_E);
			if ($urandom_range(1))
				send_request(IN_BYTE, $urandom_range(1) ? CH_MINUS : CH_PLUS);
			repeat ($urandom_range(3)) send_digit();
		end
	endtask

	task automatic send_separator();
		int r;
		r = $urandom_range(99);
		if (r < 40) begin
			send_text(" ");
		end else if (r < 55) begin
			send_request(IN_BYTE, CH_NL);
		end else if (r < 65) begin
			send_text(",");
		end else if (r < 75) begin
			send_request(IN_BYTE, CH_HASH);
			repeat ($urandom_range(4)) send_request(IN_BYTE, 8'($urandom_range(255)));
			send_request(IN_BYTE, CH_NL);
		end else begin
			send_request(IN_BYTE, 8'($urandom_range(255)));
		end
	endtask

	task automatic test_reset_limit();
		send_text("7x9");
		send_end();
	endtask

	task automatic test_number_forms();
		write_limit('1);
		send_text("-.5e+3 .+x#9");
		send_request(IN_BYTE, CH_NL);
		send_request(IN_BYTE, 8'hFF);
		send_text("1E");
		send_request(IN_BYTE, 8'h00);
		send_text("8e-");
		send_end();
	endtask

	task automatic test_limit_extremes();
		write_limit('0);
		send_text("5");
		send_end();
		write_limit(16'd2);
		send_text("1 2 3");
		send_end();
	endtask

	task automatic test_overlong();
		write_limit('1);
		repeat (int'(MAX_TOKEN_LEN) + 1) send_digit();
		send_text("1 2");
		send_end();
		send_text("1.");
		repeat (int'(MAX_TOKEN_LEN) - 2) send_digit();
		send_request(IN_BYTE, CH_LOW_E);
		send_end();
	endtask

	task automatic test_limit_lowered();
		write_limit(16'd100);
		send_text("12 34 5");
		write_limit(16'd1);
		send_text(" ");
		send_end();
		write_limit(16'd100);
		send_text("12 34 ");
		write_limit(16'd2);
		send_text("x");
		send_end();
	endtask

	task automatic test_backpressure();
		write_limit('1);
		tx_idle_pct   = 0;
		long_hold_req = 1'b1;
		repeat (10) send_text("-.5 ");
		send_end();
		wait_drained();
	endtask

	task automatic test_sender_pause();
		tx_idle_pct = 30;
		rx_idle_pct = 40;
		repeat (4) begin
			send_token();
			send_separator();
		end
		wait_drained();
		repeat (4) begin
			send_token();
			send_separator();
		end
		send_end();
	endtask

	task automatic test_random_streams();
		int stop_at;
		int r;
		stop_at = requests_sent + RANDOM_REQUESTS;
		while (requests_sent < stop_at) begin
			r = $urandom_range(99);
			if (r < 5)
				write_limit('0);
			else if (r < 15)
				write_limit(16'd1);
			else if (r < 25)
				write_limit('1);
			else
				write_limit(16'($urandom_range(12, 2)));
			tx_idle_pct = 30 * $urandom_range(2);
			rx_idle_pct = 30 * $urandom_range(2);
			repeat ($urandom_range(12, 3)) begin
				send_token();
				send_separator();
				if ($urandom_range(99) < 5)
					wait_drained();
			end
			if ($urandom_range(99) < 75)
				send_end();
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_limit();
		test_number_forms();
		test_limit_extremes();
		test_overlong();
		test_limit_lowered();
		test_backpressure();
		test_sender_pause();
		test_random_streams();
		rx_idle_pct = 0;
		wait_drained();
		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
